// ===== src/ps2ki_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2ki_pkg
// Types and byte codes shared by the PS/2 keyboard init sequencer.
// ----------------------------------------------------------------------------
package ps2ki_pkg;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_ACK_RESET = 3'd1,
        PH_SELFTEST  = 3'd2,
        PH_ACK_SET   = 3'd3,
        PH_ACK_ARG   = 3'd4,
        PH_SKIP      = 3'd5,
        PH_GET_SET   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SELFTEST = 2'd1,
        ST_BAD      = 2'd2
    } t_status;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_RX    = 1'b1;

    localparam logic [7:0] BYTE_RESET  = 8'hFF;
    localparam logic [7:0] BYTE_RESEND = 8'hFE;
    localparam logic [7:0] BYTE_ACK    = 8'hFA;
    localparam logic [7:0] BYTE_PASS   = 8'hAA;
    localparam logic [7:0] BYTE_SETCMD = 8'hF0;
    localparam logic [7:0] BYTE_QUERY  = 8'h00;
    localparam logic [7:0] SET_ONE     = 8'h43;
    localparam logic [7:0] SET_TWO     = 8'h41;
    localparam logic [7:0] SET_THREE   = 8'h3F;

    localparam logic [1:0] RETRY_RESET = 2'd3;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] set_id;
    } t_res_item;

endpackage

// ===== src/ps2ki_ifs.sv =====
// ----------------------------------------------------------------------------
// ps2ki interfaces
// Valid/ready channels: input item, result item and configuration write.
// ----------------------------------------------------------------------------
interface ps2ki_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface ps2ki_out_if;
    logic       valid;
    logic       ready;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] set_id;

    modport source (output valid, output send_valid, output send_byte,
                    output done_res, output status, output set_id, input ready);
    modport sink   (input valid, input send_valid, input send_byte,
                    input done_res, input status, input set_id, output ready);
endinterface

interface ps2ki_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] retry_limit;

    modport source (output valid, output retry_limit, input ready);
    modport sink   (input valid, input retry_limit, output ready);
endinterface

// ===== src/ps2ki_in_stage.sv =====
// ----------------------------------------------------------------------------
// ps2ki_in_stage
// Input register: holds one received transaction until the sequencer takes it.
// ----------------------------------------------------------------------------
module ps2ki_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ps2ki_pkg::t_in_item i_item,
    input  logic                i_advance,
    output logic                o_valid,
    output ps2ki_pkg::t_in_item o_item
);
    import ps2ki_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== src/ps2ki_fsm.sv =====
// ----------------------------------------------------------------------------
// ps2ki_fsm
// Handshake state machine: phase, retry count and retry limit register, and
// the result decode for one received transaction.
// ----------------------------------------------------------------------------
module ps2ki_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_retry_limit,
    input  logic                 i_fire,
    input  ps2ki_pkg::t_in_item  i_item,
    output logic                 o_has_res,
    output ps2ki_pkg::t_res_item o_res
);
    import ps2ki_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [1:0] r_retry_count;
    logic [1:0] n_retry_count;
    logic [1:0] r_retry_limit;
    logic [7:0] w_last_byte;
    t_phase     w_ack_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RETRY_RESET;
        end else if (i_cfg_we) begin
            r_retry_limit <= i_cfg_retry_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_retry_count <= 2'd0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_retry_count <= n_retry_count;
        end
    end

    always_comb begin
        case (r_phase)
            PH_ACK_RESET: begin
                w_last_byte = BYTE_RESET;
                w_ack_next  = PH_SELFTEST;
            end
            PH_ACK_SET: begin
                w_last_byte = BYTE_SETCMD;
                w_ack_next  = PH_ACK_ARG;
            end
            default: begin
                w_last_byte = BYTE_QUERY;
                w_ack_next  = PH_SKIP;
            end
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_retry_count = r_retry_count;
        o_has_res     = 1'b0;
        o_res         = '0;
        if (i_item.command == CMD_START) begin
            n_phase          = PH_ACK_RESET;
            n_retry_count    = 2'd0;
            o_has_res        = 1'b1;
            o_res.send_valid = 1'b1;
            o_res.send_byte  = BYTE_RESET;
        end else begin
            case (r_phase)
                PH_ACK_RESET, PH_ACK_SET, PH_ACK_ARG: begin
                    if (i_item.rx_byte == BYTE_RESEND) begin
                        o_has_res = 1'b1;
                        if (r_retry_count < r_retry_limit) begin
                            n_retry_count    = r_retry_count + 2'd1;
                            o_res.send_valid = 1'b1;
                            o_res.send_byte  = w_last_byte;
                        end else begin
                            n_phase        = PH_IDLE;
                            o_res.done_res = 1'b1;
                            o_res.status   = ST_BAD;
                        end
                    end else if (i_item.rx_byte == BYTE_ACK) begin
                        n_phase       = w_ack_next;
                        n_retry_count = 2'd0;
                        if (r_phase == PH_ACK_SET) begin
                            o_has_res        = 1'b1;
                            o_res.send_valid = 1'b1;
                            o_res.send_byte  = BYTE_QUERY;
                        end
                    end else begin
                        n_phase        = PH_IDLE;
                        o_has_res      = 1'b1;
                        o_res.done_res = 1'b1;
                        o_res.status   = ST_BAD;
                    end
                end
                PH_SELFTEST: begin
                    o_has_res = 1'b1;
                    if (i_item.rx_byte == BYTE_PASS) begin
                        n_phase          = PH_ACK_SET;
                        n_retry_count    = 2'd0;
                        o_res.send_valid = 1'b1;
                        o_res.send_byte  = BYTE_SETCMD;
                    end else begin
                        n_phase        = PH_IDLE;
                        o_res.done_res = 1'b1;
                        o_res.status   = ST_SELFTEST;
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_GET_SET;
                end
                PH_GET_SET: begin
                    n_phase        = PH_IDLE;
                    o_has_res      = 1'b1;
                    o_res.done_res = 1'b1;
                    if (i_item.rx_byte inside {SET_ONE, SET_TWO, SET_THREE}) begin
                        o_res.status = ST_OK;
                        o_res.set_id = i_item.rx_byte;
                    end else begin
                        o_res.status = ST_BAD;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/ps2ki_out_stage.sv =====
// ----------------------------------------------------------------------------
// ps2ki_out_stage
// Result register: holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module ps2ki_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ps2ki_pkg::t_res_item i_res,
    output logic                 o_can_load,
    input  logic                 i_ready,
    output logic                 o_valid,
    output ps2ki_pkg::t_res_item o_res
);
    import ps2ki_pkg::*;

    logic      r_valid;
    t_res_item r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== src/ps2_keyboard_init_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// ps2_keyboard_init_sequencer_unit
// Host-side PS/2 keyboard reset and scancode-set query sequencer.
// ----------------------------------------------------------------------------
// Each input transaction (a start command or a received keyboard byte) is
// registered, decoded combinationally against the current phase, and its
// result (a byte to send or a finish status) is placed in an output register.
// One transaction is taken per clock cycle unless the input stalls. Bytes that
// only advance the phase produce no result. The input stalls only while the
// output register is full and not being drained.
// The retry limit register accepts a write every cycle.
module ps2_keyboard_init_sequencer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ps2ki_in_if.sink     i_in,
    ps2ki_out_if.source  o_out,
    ps2ki_cfg_if.sink    i_cfg
);
    import ps2ki_pkg::*;

    t_in_item  w_in_item;
    t_in_item  w_stage_item;
    logic      w_stage_valid;
    logic      w_advance;
    logic      w_has_res;
    t_res_item w_res;
    logic      w_out_can_load;
    t_res_item w_out_res;

    assign w_in_item.command = i_in.command;
    assign w_in_item.rx_byte = i_in.rx_byte;
    assign i_cfg.ready       = 1'b1;
    assign w_advance         = w_stage_valid && (!w_has_res || w_out_can_load);

    ps2ki_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_item    (w_stage_item)
    );

    ps2ki_fsm u_fsm (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_retry_limit (i_cfg.retry_limit),
        .i_fire            (w_advance),
        .i_item            (w_stage_item),
        .o_has_res         (w_has_res),
        .o_res             (w_res)
    );

    ps2ki_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance && w_has_res),
        .i_res      (w_res),
        .o_can_load (w_out_can_load),
        .i_ready    (o_out.ready),
        .o_valid    (o_out.valid),
        .o_res      (w_out_res)
    );

    assign o_out.send_valid = w_out_res.send_valid;
    assign o_out.send_byte  = w_out_res.send_byte;
    assign o_out.done_res   = w_out_res.done_res;
    assign o_out.status     = w_out_res.status;
    assign o_out.set_id     = w_out_res.set_id;

endmodule

// ===== src/ps2ki_checker.sv =====
// ----------------------------------------------------------------------------
// ps2ki_checker
// Port-level checks on the sequencer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ps2ki_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_send_valid,
    input logic [7:0] i_send_byte,
    input logic       i_done_res,
    input logic [1:0] i_status,
    input logic [7:0] i_set_id
);
    import ps2ki_pkg::*;

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_send_valid != i_done_res))
        else $error("result is neither or both send and done");

    a_send_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_send_valid) |->
            (i_status == ST_OK && i_set_id == 8'h00 &&
             (i_send_byte == BYTE_RESET || i_send_byte == BYTE_SETCMD ||
              i_send_byte == BYTE_QUERY)))
        else $error("bad send transaction");

    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_done_res) |->
            (i_send_byte == 8'h00 &&
             ((i_status == ST_OK && (i_set_id == SET_ONE || i_set_id == SET_TWO ||
                                     i_set_id == SET_THREE)) ||
              ((i_status == ST_SELFTEST || i_status == ST_BAD) && i_set_id == 8'h00))))
        else $error("bad done transaction");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_send_byte) && $stable(i_status) &&
             $stable(i_set_id)))
        else $error("stalled result changed");

endmodule

bind ps2_keyboard_init_sequencer_unit ps2ki_checker u_ps2ki_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_send_valid (o_out.send_valid),
    .i_send_byte  (o_out.send_byte),
    .i_done_res   (o_out.done_res),
    .i_status     (o_out.status),
    .i_set_id     (o_out.set_id)
);

// ===== sim/tb_ps2_keyboard_init_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_ps2_keyboard_init_sequencer_unit
// Self-checking bench for the PS/2 keyboard bring-up sequencer. A scoreboard
// tracks the host handshake (reset, self-test, scancode-set query) and
// predicts each byte to send or finish status. Stimulus is a directed opening,
// then randomized bring-up sessions with resends, broken replies and restarts,
// under several retry limits, random input gaps and random result backpressure.
// ----------------------------------------------------------------------------
module tb_ps2_keyboard_init_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2ki_pkg::*;

    class init_handshake_scoreboard;
        logic [1:0]  retry_limit;
        t_phase      phase;
        logic [1:0]  retry_count;
        logic        ready_flag;
        logic [7:0]  reported_set;
        t_res_item   expected_replies[$];
        int          n_errors;
        int          n_items;
        int          n_ignored;
        int          n_results;

        function new();
            retry_limit  = RETRY_RESET;
            phase        = PH_IDLE;
            retry_count  = '0;
            ready_flag   = 1'b0;
            reported_set = '0;
        endfunction

        task report_mismatch(string msg);
            n_errors++;
            if (n_errors <= 50) begin
                $display("MISMATCH: %s", msg);
            end
        endtask

        function void set_retry_limit(logic [1:0] value);
            retry_limit = value;
        endfunction

        function t_res_item byte_to_send(logic [7:0] b);
            t_res_item r;
            r = '0;
            r.send_valid = 1'b1;
            r.send_byte  = b;
            return r;
        endfunction

        function t_res_item finish(t_status st, logic [7:0] id);
            t_res_item r;
            phase = PH_IDLE;
            r = '0;
            r.done_res = 1'b1;
            r.status   = st;
            r.set_id   = (st == ST_OK) ? id : 8'h00;
            return r;
        endfunction

        // reply to a sent command: ack advances, resend repeats within the limit
        function bit command_reply(logic [7:0] rx, logic [7:0] last, t_phase next_phase,
                                   bit send_next, logic [7:0] next_byte,
                                   output t_res_item r);
            r = '0;
            if (rx == BYTE_RESEND) begin
                if (retry_count < retry_limit) begin
                    retry_count = retry_count + 2'd1;
                    r = byte_to_send(last);
                end else begin
                    r = finish(ST_BAD, 8'h00);
                end
                return 1'b1;
            end
            if (rx == BYTE_ACK) begin
                phase = next_phase;
                retry_count = '0;
                if (send_next) begin
                    r = byte_to_send(next_byte);
                    return 1'b1;
                end
                return 1'b0;
            end
            r = finish(ST_BAD, 8'h00);
            return 1'b1;
        endfunction

        function void note_rx_item(t_in_item it);
            t_res_item r;
            bit        has_reply;
            n_items++;
            r = '0;
            has_reply = 1'b0;
            if (it.command == CMD_START) begin
                phase        = PH_ACK_RESET;
                retry_count  = '0;
                ready_flag   = 1'b0;
                reported_set = '0;
                r = byte_to_send(BYTE_RESET);
                has_reply = 1'b1;
            end else begin
                case (phase)
                    PH_IDLE: begin
                        n_ignored++;
                    end
                    PH_ACK_RESET: begin
                        has_reply = command_reply(it.rx_byte, BYTE_RESET, PH_SELFTEST,
                                                  1'b0, BYTE_QUERY, r);
                    end
                    PH_SELFTEST: begin
                        if (it.rx_byte == BYTE_PASS) begin
                            phase = PH_ACK_SET;
                            retry_count = '0;
                            r = byte_to_send(BYTE_SETCMD);
                        end else begin
                            r = finish(ST_SELFTEST, 8'h00);
                        end
                        has_reply = 1'b1;
                    end
                    PH_ACK_SET: begin
                        has_reply = command_reply(it.rx_byte, BYTE_SETCMD, PH_ACK_ARG,
                                                  1'b1, BYTE_QUERY, r);
                    end
                    PH_ACK_ARG: begin
                        has_reply = command_reply(it.rx_byte, BYTE_QUERY, PH_SKIP,
                                                  1'b0, BYTE_QUERY, r);
                    end
                    PH_SKIP: begin
                        phase = PH_GET_SET;
                    end
                    PH_GET_SET: begin
                        if (it.rx_byte == SET_ONE || it.rx_byte == SET_TWO ||
                            it.rx_byte == SET_THREE) begin
                            reported_set = it.rx_byte;
                            ready_flag = 1'b1;
                            r = finish(ST_OK, it.rx_byte);
                        end else begin
                            r = finish(ST_BAD, 8'h00);
                        end
                        has_reply = 1'b1;
                    end
                    default: begin
                        phase = PH_IDLE;
                    end
                endcase
            end
            if (has_reply) begin
                expected_replies.push_back(r);
            end
        endfunction

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                          n_results, name, got, want));
            end
        endtask

        task check_reply(t_res_item got);
            t_res_item want;
            n_results++;
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("result %0d not expected: %h", n_results, got));
                return;
            end
            want = expected_replies.pop_front();
            compare_field("send_valid", 8'(got.send_valid), 8'(want.send_valid));
            compare_field("send_byte",  got.send_byte,      want.send_byte);
            compare_field("done_res",   8'(got.done_res),   8'(want.done_res));
            compare_field("status",     8'(got.status),     8'(want.status));
            compare_field("set_id",     got.set_id,         want.set_id);
        endtask
    endclass

    localparam int DRAIN_CYCLES  = 4;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_ITEMS   = 200;
    localparam int N_PHASES      = 7;
    localparam int TIMEOUT_NS    = 5_000_000;

    logic i_clk;
    logic i_rst_n;

    ps2ki_in_if  in_if();
    ps2ki_out_if out_if();
    ps2ki_cfg_if cfg_if();

    ps2_keyboard_init_sequencer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    init_handshake_scoreboard sb = new();

    logic [1:0] cur_limit;
    int         src_gap_rate;
    bit         quiet;
    bit         hold_req;
    int         hold_count;
    int         n_holds;
    int         n_sessions;
    int         n_cfg_writes;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("ps2_keyboard_init_sequencer_unit: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            sb.note_rx_item(t_in_item'({in_if.command, in_if.rx_byte}));
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_reply(t_res_item'({out_if.send_valid, out_if.send_byte,
                                        out_if.done_res, out_if.status, out_if.set_id}));
        end
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            sb.set_retry_limit(cfg_if.retry_limit);
        end
    end

    // result receiver: random stalls, one long hold-off on request
    initial begin
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_req) begin
                out_if.ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    @(posedge i_clk);
                end
                hold_req = 1'b0;
                n_holds++;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(logic cmd, logic [7:0] b);
        if (src_gap_rate != 0 && $urandom_range(1, 8) <= src_gap_rate) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.command <= cmd;
        in_if.rx_byte <= b;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
    endtask

    task automatic send_start();
        send_item(CMD_START, 8'($urandom));
    endtask

    task automatic send_rx(logic [7:0] b);
        send_item(CMD_RX, b);
    endtask

    task automatic wait_until_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_retry_limit(logic [1:0] value);
        cfg_if.valid       <= 1'b1;
        cfg_if.retry_limit <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        cur_limit = value;
        n_cfg_writes++;
        @(posedge i_clk);
    endtask

    // keyboard reply to one host command: some resends, then ack or junk
    task automatic answer_command(inout bit alive);
        int n;
        if (!alive) return;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cur_limit) : 0;
        if ($urandom_range(0, 29) == 0) n = cur_limit + 1;
        repeat (n) send_rx(BYTE_RESEND);
        if (n > cur_limit) begin
            alive = 1'b0;
            return;
        end
        if ($urandom_range(0, 29) == 0) begin
            send_rx(8'($urandom));
            alive = 1'b0;
            return;
        end
        send_rx(BYTE_ACK);
    endtask

    task automatic run_session();
        bit         alive;
        logic [7:0] b;
        alive = 1'b1;
        n_sessions++;
        src_gap_rate = quiet ? 0 : $urandom_range(0, 3);
        send_start();
        if ($urandom_range(0, 24) == 0) send_start();
        answer_command(alive);
        if (alive) begin
            if ($urandom_range(0, 14) == 0) begin
                b = 8'($urandom);
                alive = (b == BYTE_PASS);
                send_rx(b);
            end else begin
                send_rx(BYTE_PASS);
            end
        end
        answer_command(alive);
        if (alive && $urandom_range(0, 39) == 0) begin
            send_start();
            alive = 1'b0;
        end
        answer_command(alive);
        if (alive) begin
            send_rx(8'($urandom));
            case ($urandom_range(0, 7))
                0, 1:    b = SET_ONE;
                2, 3:    b = SET_TWO;
                4, 5:    b = SET_THREE;
                default: b = 8'($urandom);
            endcase
            send_rx(b);
        end
        if ($urandom_range(0, 9) == 0) send_rx(8'($urandom));
    endtask

    initial begin
        int         target;
        logic [1:0] lim;
        logic [1:0] plan [4];

        plan = '{2'd1, 2'd3, 2'd2, 2'd0};
        cur_limit    = RETRY_RESET;
        src_gap_rate = 2;
        quiet        = 1'b0;
        hold_req     = 1'b0;

        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.command      <= CMD_START;
        in_if.rx_byte      <= 8'h00;
        out_if.ready       <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.retry_limit <= RETRY_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening with the reset retry limit
        send_rx(8'h00);
        send_rx(8'hFF);
        send_start();
        send_rx(BYTE_RESEND);
        send_rx(BYTE_ACK);
        send_rx(BYTE_PASS);
        send_rx(BYTE_RESEND);
        send_rx(BYTE_ACK);
        send_rx(BYTE_RESEND);
        send_rx(BYTE_ACK);
        send_rx(8'h00);
        send_rx(SET_ONE);
        send_start();
        send_start();
        send_rx(BYTE_ACK);
        send_rx(8'h12);
        send_start();
        repeat (4) send_rx(BYTE_RESEND);
        send_start();
        send_rx(BYTE_ACK);
        send_rx(BYTE_PASS);
        send_rx(8'h7F);
        wait_until_drained();

        write_retry_limit(2'd0);
        send_start();
        send_rx(BYTE_RESEND);
        wait_until_drained();

        target = sb.n_items - sb.n_ignored;
        for (int p = 0; p < N_PHASES; p++) begin
            lim = (p < 4) ? plan[p] : 2'($urandom);
            write_retry_limit(lim);
            if (p == 2) hold_req = 1'b1;
            if (p == N_PHASES - 1) quiet = 1'b1;
            target += PHASE_ITEMS;
            while (sb.n_items - sb.n_ignored < target) run_session();
            wait_until_drained();
        end

        $display("Covered %0d input transactions (%0d ignored while idle), %0d results",
                 sb.n_items, sb.n_ignored, sb.n_results);
        $display("over %0d bring-up sessions, %0d retry-limit writes, %0d long output holds",
                 n_sessions, n_cfg_writes, n_holds);
        if (sb.n_errors == 0) begin
            $display("ps2_keyboard_init_sequencer_unit: match");
        end else begin
            $display("ps2_keyboard_init_sequencer_unit: mismatch");
        end
        $finish;
    end
endmodule
